// ===== hdl/game_port_buttons_and_paddles_defines.svh =====
// Assertion macros for the game port block.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef GAME_PORT_BUTTONS_AND_PADDLES_DEFINES_SVH
`define GAME_PORT_BUTTONS_AND_PADDLES_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define GPBP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define GPBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gpbp_pkg.sv =====
// Shared types, constants and helper functions for the game port block.
// No dependencies.
`default_nettype none

package gpbp_pkg;

  localparam int CYCLE_BITS  = 48;  // width of the cycle counter kept inside
  localparam int CYCLE_IN_W  = 48;  // width of the cycle field on the port
  localparam int CMD_W       = 3;
  localparam int INDEX_W     = 2;
  localparam int POS_W       = 8;
  localparam int US_W        = 16;
  localparam int DELAY_W     = 12;  // paddle delay never exceeds 3092
  localparam int NUM_BUTTONS = 3;
  localparam int NUM_PADDLES = 4;
  localparam int AUTOFIRE_W  = 3;
  localparam int STICK_W     = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [US_W-1:0]  LATCH_RESET  = US_W'(5000);
  localparam logic [STICK_W-1:0] STICK_RESET = STICK_W'(1);
  localparam logic [POS_W-1:0] PDL_CENTER   = POS_W'(127);
  localparam logic [POS_W-1:0] PDL_FULL     = POS_W'(255);
  localparam logic [POS_W:0]   PDL_FULL_AS  = (POS_W+1)'(280);

  typedef enum logic [CMD_W-1:0] {
    CMD_TIME     = 3'd0,
    CMD_LEVEL    = 3'd1,
    CMD_PADDLE   = 3'd2,
    CMD_TRIGGER  = 3'd3,
    CMD_READ_BTN = 3'd4,
    CMD_READ_PDL = 3'd5
  } cmd_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTOFIRE = 2'd0,
    CFG_STICK    = 2'd1,
    CFG_LATCH    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    cmd_e_t                cmd;
    logic [INDEX_W-1:0]    index;
    logic                  level;
    logic [POS_W-1:0]      position;
    logic [US_W-1:0]       elapsed_us;
    logic [CYCLE_IN_W-1:0] cycle;
  } item_t;

  // floor(p * 2816 / 255) with full scale read as 280.
  // Split as 11*p + floor(11*p / 255); the small quotient uses the
  // add-high-byte trick, exact for values below 65535.
  function automatic logic [DELAY_W-1:0] pdl_delay(input logic [POS_W-1:0] p);
    logic [POS_W:0]     pe;
    logic [DELAY_W-1:0] y;
    logic [DELAY_W-1:0] q;
    pe = (p == PDL_FULL) ? PDL_FULL_AS : {1'b0, p};
    y  = DELAY_W'({pe, 3'b000}) + DELAY_W'({pe, 1'b0}) + DELAY_W'(pe);
    q  = (y + (y >> 8) + DELAY_W'(1)) >> 8;
    return y + q;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gpbp_buttons.sv =====
// Push-button latches, levels and autofire state for the game port.
// Depends on gpbp_pkg.
`default_nettype none

module gpbp_buttons (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                en,
  input  wire gpbp_pkg::item_t               item,
  input  wire [gpbp_pkg::AUTOFIRE_W-1:0]     autofire_mask,
  input  wire [gpbp_pkg::US_W-1:0]           latch_time_us,
  output logic                               btn_bit
);
  import gpbp_pkg::*;

  logic [US_W-1:0] latch_r   [NUM_BUTTONS];
  logic [US_W-1:0] latch_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] held_r,  held_nxt;
  logic [NUM_BUTTONS-1:0] phase_r, phase_nxt;
  logic [NUM_BUTTONS-1:0] last_r,  last_nxt;
  logic [INDEX_W-1:0] sel;
  logic valid_btn;
  logic pressed;

  assign sel       = item.index;
  assign valid_btn = (int'(item.index) < NUM_BUTTONS);

  always_comb begin
    latch_nxt = latch_r;
    held_nxt  = held_r;
    phase_nxt = phase_r;
    last_nxt  = last_r;
    btn_bit   = 1'b0;
    pressed   = 1'b0;
    case (item.cmd)
      CMD_TIME: begin
        // count down, saturate at zero
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          latch_nxt[i] = (latch_r[i] > item.elapsed_us) ? latch_r[i] - item.elapsed_us
                                                        : '0;
        end
      end
      CMD_LEVEL: begin
        if (valid_btn) begin
          if (item.level && !held_r[sel]) begin
            latch_nxt[sel] = latch_time_us;
          end
          held_nxt[sel] = item.level;
        end
      end
      CMD_READ_BTN: begin
        if (valid_btn) begin
          pressed        = (latch_r[sel] != '0) || held_r[sel];
          latch_nxt[sel] = '0;
          btn_bit        = pressed;
          if (autofire_mask[sel] && pressed) begin
            // toggle on back-to-back pressed reads, restart high otherwise
            phase_nxt[sel] = last_r[sel] ? ~phase_r[sel] : 1'b1;
            btn_bit        = phase_nxt[sel];
          end
          last_nxt[sel] = pressed;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        latch_r[i] <= '0;
      end
      held_r  <= '0;
      phase_r <= '0;
      last_r  <= '0;
    end else if (en) begin
      latch_r <= latch_nxt;
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gpbp_paddles.sv =====
// Paddle positions (kept as timer delays) and the timer trigger cycle.
// Depends on gpbp_pkg.
`default_nettype none

module gpbp_paddles (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              en,
  input  wire gpbp_pkg::item_t             item,
  input  wire [gpbp_pkg::STICK_W-1:0]      stick_present,
  output logic                             pdl_bit
);
  import gpbp_pkg::*;

  logic [DELAY_W-1:0]    delay_r [NUM_PADDLES];
  logic [CYCLE_BITS-1:0] trig_r;
  logic [CYCLE_BITS-1:0] cyc;
  logic [CYCLE_BITS:0]   limit;

  assign cyc = CYCLE_BITS'(item.cycle);

  // One bit of headroom stands in for saturation: once the sum passes the
  // counter range, any cycle compares as still inside the window.
  assign limit   = {1'b0, trig_r} + (CYCLE_BITS+1)'(delay_r[item.index]);
  assign pdl_bit = !stick_present[item.index[1]] || ({1'b0, cyc} <= limit);

  // Store the delay, not the raw position: keeps the multiply off the read path.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PADDLES; i++) begin
        delay_r[i] <= pdl_delay(PDL_CENTER);
      end
      trig_r <= '0;
    end else if (en) begin
      case (item.cmd)
        CMD_PADDLE:  delay_r[item.index] <= pdl_delay(item.position);
        CMD_TRIGGER: trig_r <= cyc;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/game_port_buttons_and_paddles.sv =====
// Game port: three push buttons with press latches and autofire, four paddle
// timers. Takes one command per clock unless stalled and returns one result per
// read command, from the input register through the result register. State
// updates of one command are seen by the next. The paddle read, a CYCLE_BITS+1
// wide add and compare against the trigger cycle, sets the clock period. A read
// in the input register waits while the result register is full and stalled,
// and the input side stalls with it; any other command advances regardless.
`default_nettype none
`include "game_port_buttons_and_paddles_defines.svh"

module game_port_buttons_and_paddles (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire [gpbp_pkg::CMD_W-1:0]          in_cmd,
  input  wire [gpbp_pkg::INDEX_W-1:0]        in_index,
  input  wire                                in_level,
  input  wire [gpbp_pkg::POS_W-1:0]          in_position,
  input  wire [gpbp_pkg::US_W-1:0]           in_elapsed_us,
  input  wire [gpbp_pkg::CYCLE_IN_W-1:0]     in_cycle,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_read_bit,
  input  wire                                cfg_we,
  input  wire [gpbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [gpbp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gpbp_pkg::*;

  logic [AUTOFIRE_W-1:0] autofire_r;
  logic [STICK_W-1:0]    stick_r;
  logic [US_W-1:0]       latch_time_r;

  item_t s1_item_r;
  logic  s1_valid_r;
  logic  out_valid_r;
  logic  out_read_bit_r;
  logic  is_read;
  logic  adv;
  logic  accept;
  logic  btn_bit;
  logic  pdl_bit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      autofire_r   <= '0;
      stick_r      <= STICK_RESET;
      latch_time_r <= LATCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTOFIRE: autofire_r   <= AUTOFIRE_W'(cfg_data);
        CFG_STICK:    stick_r      <= STICK_W'(cfg_data);
        CFG_LATCH:    latch_time_r <= US_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign is_read  = (s1_item_r.cmd == CMD_READ_BTN) || (s1_item_r.cmd == CMD_READ_PDL);
  // advance unless a read has nowhere to go
  assign adv      = s1_valid_r && (!is_read || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept || (s1_valid_r && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= '{cmd:        cmd_e_t'(in_cmd),
                     index:      in_index,
                     level:      in_level,
                     position:   in_position,
                     elapsed_us: in_elapsed_us,
                     cycle:      in_cycle};
    end
  end

  gpbp_buttons u_buttons (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .item          (s1_item_r),
    .autofire_mask (autofire_r),
    .latch_time_us (latch_time_r),
    .btn_bit       (btn_bit)
  );

  gpbp_paddles u_paddles (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .item          (s1_item_r),
    .stick_present (stick_r),
    .pdl_bit       (pdl_bit)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && is_read) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_read) begin
      out_read_bit_r <= (s1_item_r.cmd == CMD_READ_BTN) ? btn_bit : pdl_bit;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_read_bit = out_read_bit_r;

  `GPBP_ASSERT_IMPL(a_stall_needs_item, in_stall, s1_valid_r, "stall with empty stage")
  `GPBP_ASSERT_IMPL(a_free_out_advances, s1_valid_r && !out_valid_r, adv, "stage stuck")
  `GPBP_ASSERT_NEXT(a_read_gives_result, adv && is_read, out_valid_r, "read gave no result")
  `GPBP_ASSERT_NEXT(a_no_stray_result, adv && !is_read && !out_valid_r, !out_valid_r, "stray")

endmodule

`default_nettype wire
